FILE: rtl/core/rwla_pkg.sv
package rwla_pkg;

    localparam int READ_WAIT_DEPTH  = 16;
    localparam int WRITE_WAIT_DEPTH = 16;
    localparam int ID_BITS          = 8;
    localparam int MAX_READERS      = 255;
    localparam int RESULT_CAP       = 16;

    localparam int OP_W  = 3;
    localparam int EV_W  = 3;
    localparam int RID_W = 8;
    localparam int TID_W = 8;

    localparam int RQ_AW = (READ_WAIT_DEPTH > 1) ? $clog2(READ_WAIT_DEPTH) : 1;
    localparam int RQ_CW = $clog2(READ_WAIT_DEPTH + 1);
    localparam int WQ_AW = (WRITE_WAIT_DEPTH > 1) ? $clog2(WRITE_WAIT_DEPTH) : 1;
    localparam int WQ_CW = $clog2(WRITE_WAIT_DEPTH + 1);
    localparam int RC_W  = $clog2(MAX_READERS + 1);
    localparam int EC_W  = $clog2(RESULT_CAP + 1);

    typedef logic [ID_BITS-1:0] id_t;

    typedef enum logic [OP_W-1:0] {
        OP_RLOCK   = 3'd0,
        OP_RUNLOCK = 3'd1,
        OP_WLOCK   = 3'd2,
        OP_WUNLOCK = 3'd3,
        OP_RETIRE  = 3'd4
    } opcode_t;

    typedef enum logic [EV_W-1:0] {
        EV_RGRANT  = 3'd0,
        EV_WGRANT  = 3'd1,
        EV_RREFUSE = 3'd2,
        EV_WREFUSE = 3'd3,
        EV_RETIRED = 3'd4,
        EV_ERROR   = 3'd5
    } event_t;

    typedef struct packed {
        logic             busy;
        logic             write_held;
        logic [RC_W-1:0]  reader_count;
        logic [RQ_CW-1:0] rq_count;
        logic [WQ_CW-1:0] wq_count;
    } rwla_status_t;

endpackage

FILE: rtl/core/reader_writer_lock_arbiter.sv
// Reader-writer lock arbiter.
// Input channel (in_valid/in_ready): one request word per handshake, opcode
// (read lock, read unlock, write lock, write unlock, retire) and requester_id.
// Output channel (out_valid/out_ready): result words of event_kind and
// target_id; last_of_run marks the final word caused by a request. A request
// may cause no word at all (queued lock, retire while busy, quiet unlock).
// Timing: a request is taken in S_IDLE and decided in S_DECIDE once the
// output register frees; result words come from the output register. A
// release that drains queued readers goes on to S_DRAIN: one grant word per
// cycle while the output register is free, up to 16, while input is held off.
// Waiting requesters sit in two FIFO memories with a registered read port;
// the pop address follows the queue head so each pop finds its word ready.
// The output register lets a new request be taken while a word waits.
// When out_ready is low the decision step and the drain hold until the
// output register frees; no word is dropped.
// Reset: lock free, no readers, both queues empty, no retire pending. A
// completed retire returns the block to this same state.
module reader_writer_lock_arbiter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rwla_pkg::OP_W-1:0]  opcode,
    input  logic [rwla_pkg::RID_W-1:0] requester_id,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rwla_pkg::EV_W-1:0]  event_kind,
    output logic [rwla_pkg::TID_W-1:0] target_id,
    output logic                       last_of_run
);

    import rwla_pkg::*;

    logic             rq_we;
    logic [RQ_AW-1:0] rq_waddr;
    id_t              rq_wdata;
    logic [RQ_AW-1:0] rq_raddr;
    id_t              rq_rdata;
    logic             wq_we;
    logic [WQ_AW-1:0] wq_waddr;
    id_t              wq_wdata;
    logic [WQ_AW-1:0] wq_raddr;
    id_t              wq_rdata;
    rwla_status_t     status;

    rwla_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .requester_id (requester_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .target_id    (target_id),
        .last_of_run  (last_of_run),
        .rq_we        (rq_we),
        .rq_waddr     (rq_waddr),
        .rq_wdata     (rq_wdata),
        .rq_raddr     (rq_raddr),
        .rq_rdata     (rq_rdata),
        .wq_we        (wq_we),
        .wq_waddr     (wq_waddr),
        .wq_wdata     (wq_wdata),
        .wq_raddr     (wq_raddr),
        .wq_rdata     (wq_rdata),
        .status       (status)
    );

    rwla_ram #(
        .DEPTH (READ_WAIT_DEPTH),
        .WIDTH (ID_BITS)
    ) u_read_queue (
        .clk   (clk),
        .we    (rq_we),
        .waddr (rq_waddr),
        .wdata (rq_wdata),
        .raddr (rq_raddr),
        .rdata (rq_rdata)
    );

    rwla_ram #(
        .DEPTH (WRITE_WAIT_DEPTH),
        .WIDTH (ID_BITS)
    ) u_write_queue (
        .clk   (clk),
        .we    (wq_we),
        .waddr (wq_waddr),
        .wdata (wq_wdata),
        .raddr (wq_raddr),
        .rdata (wq_rdata)
    );

`ifndef SYNTH
    a_writer_excludes_readers: assert property (@(posedge clk) disable iff (!rst_n)
        status.write_held |-> status.reader_count == '0)
        else $error("writer holds lock while readers are counted");

    a_idle_lock_no_waiters: assert property (@(posedge clk) disable iff (!rst_n)
        (!status.busy && !status.write_held && status.reader_count == '0)
        |-> (status.rq_count == '0 && status.wq_count == '0))
        else $error("lock free with requesters still queued");

    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        status.rq_count <= RQ_CW'(READ_WAIT_DEPTH) &&
        status.wq_count <= WQ_CW'(WRITE_WAIT_DEPTH))
        else $error("wait queue count beyond depth");

    a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken before decision");
`endif

endmodule

FILE: rtl/core/rwla_ram.sv
module rwla_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/rwla_ctrl.sv
module rwla_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rwla_pkg::OP_W-1:0]  opcode,
    input  logic [rwla_pkg::RID_W-1:0] requester_id,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rwla_pkg::EV_W-1:0]  event_kind,
    output logic [rwla_pkg::TID_W-1:0] target_id,
    output logic                       last_of_run,
    output logic                       rq_we,
    output logic [rwla_pkg::RQ_AW-1:0] rq_waddr,
    output rwla_pkg::id_t              rq_wdata,
    output logic [rwla_pkg::RQ_AW-1:0] rq_raddr,
    input  rwla_pkg::id_t              rq_rdata,
    output logic                       wq_we,
    output logic [rwla_pkg::WQ_AW-1:0] wq_waddr,
    output rwla_pkg::id_t              wq_wdata,
    output logic [rwla_pkg::WQ_AW-1:0] wq_raddr,
    input  rwla_pkg::id_t              wq_rdata,
    output rwla_pkg::rwla_status_t     status
);

    import rwla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_DRAIN
    } state_t;

    state_t           state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    id_t              id_reg, id_next;
    logic             write_held_reg, write_held_next;
    logic [RC_W-1:0]  reader_count_reg, reader_count_next;
    logic [RQ_AW-1:0] rq_head_reg, rq_head_next;
    logic [RQ_CW-1:0] rq_count_reg, rq_count_next;
    logic [WQ_AW-1:0] wq_head_reg, wq_head_next;
    logic [WQ_CW-1:0] wq_count_reg, wq_count_next;
    logic             retire_pending_reg, retire_pending_next;
    id_t              retire_id_reg, retire_id_next;
    logic [EC_W-1:0]  emitted_reg, emitted_next;
    logic             out_valid_reg, out_valid_next;
    event_t           out_kind_reg, out_kind_next;
    id_t              out_id_reg, out_id_next;
    logic             out_last_reg, out_last_next;

    logic             out_free;
    logic             emit;
    event_t           emit_kind;
    id_t              emit_id;
    logic             emit_last;
    logic             rq_pop;
    logic             wq_pop;
    logic             do_reset;
    logic [RQ_CW:0]   rq_tail_sum;
    logic [WQ_CW:0]   wq_tail_sum;
    logic [RQ_AW-1:0] rq_tail;
    logic [WQ_AW-1:0] wq_tail;
    logic [RQ_AW-1:0] rq_head_inc;
    logic [WQ_AW-1:0] wq_head_inc;
    logic             rq_full;
    logic             wq_full;

    assign out_free = !out_valid_reg || out_ready;
    assign rq_full  = (rq_count_reg == RQ_CW'(READ_WAIT_DEPTH));
    assign wq_full  = (wq_count_reg == WQ_CW'(WRITE_WAIT_DEPTH));

    always_comb
    begin
        rq_tail_sum = (RQ_CW+1)'(rq_head_reg) + (RQ_CW+1)'(rq_count_reg);
        if (rq_tail_sum >= (RQ_CW+1)'(READ_WAIT_DEPTH))
        begin
            rq_tail_sum = rq_tail_sum - (RQ_CW+1)'(READ_WAIT_DEPTH);
        end
        rq_tail = rq_tail_sum[RQ_AW-1:0];
        wq_tail_sum = (WQ_CW+1)'(wq_head_reg) + (WQ_CW+1)'(wq_count_reg);
        if (wq_tail_sum >= (WQ_CW+1)'(WRITE_WAIT_DEPTH))
        begin
            wq_tail_sum = wq_tail_sum - (WQ_CW+1)'(WRITE_WAIT_DEPTH);
        end
        wq_tail = wq_tail_sum[WQ_AW-1:0];
    end

    assign rq_head_inc = (rq_head_reg == RQ_AW'(READ_WAIT_DEPTH - 1)) ? '0
                                                                        : rq_head_reg + 1'b1;
    assign wq_head_inc = (wq_head_reg == WQ_AW'(WRITE_WAIT_DEPTH - 1)) ? '0
                                                                         : wq_head_reg + 1'b1;

    always_comb
    begin
        state_next          = state_reg;
        op_next             = op_reg;
        id_next             = id_reg;
        write_held_next     = write_held_reg;
        reader_count_next   = reader_count_reg;
        rq_head_next        = rq_head_reg;
        rq_count_next       = rq_count_reg;
        wq_head_next        = wq_head_reg;
        wq_count_next       = wq_count_reg;
        retire_pending_next = retire_pending_reg;
        retire_id_next      = retire_id_reg;
        emitted_next        = emitted_reg;
        emit                = 1'b0;
        emit_kind           = EV_ERROR;
        emit_id             = id_reg;
        emit_last           = 1'b1;
        rq_we               = 1'b0;
        wq_we               = 1'b0;
        rq_pop              = 1'b0;
        wq_pop              = 1'b0;
        do_reset            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    id_next    = requester_id[ID_BITS-1:0];
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_RLOCK:
                        begin
                            if (write_held_reg || wq_count_reg != '0 || rq_count_reg != '0)
                            begin
                                if (rq_full)
                                begin
                                    emit      = 1'b1;
                                    emit_kind = EV_RREFUSE;
                                end
                                else
                                begin
                                    rq_we         = 1'b1;
                                    rq_count_next = rq_count_reg + 1'b1;
                                end
                            end
                            else if (reader_count_reg == RC_W'(MAX_READERS))
                            begin
                                emit      = 1'b1;
                                emit_kind = EV_RREFUSE;
                            end
                            else
                            begin
                                reader_count_next = reader_count_reg + 1'b1;
                                emit              = 1'b1;
                                emit_kind         = EV_RGRANT;
                            end
                        end
                        OP_RUNLOCK:
                        begin
                            if (write_held_reg || reader_count_reg == '0)
                            begin
                                emit      = 1'b1;
                                emit_kind = EV_ERROR;
                            end
                            else
                            begin
                                reader_count_next = reader_count_reg - 1'b1;
                                if (wq_count_reg != '0)
                                begin
                                    if (reader_count_reg == RC_W'(1))
                                    begin
                                        wq_pop          = 1'b1;
                                        write_held_next = 1'b1;
                                        emit            = 1'b1;
                                        emit_kind       = EV_WGRANT;
                                        emit_id         = wq_rdata;
                                    end
                                end
                                else if (rq_count_reg != '0)
                                begin
                                    emitted_next = '0;
                                    state_next   = S_DRAIN;
                                end
                                else if (retire_pending_reg && reader_count_reg == RC_W'(1))
                                begin
                                    do_reset  = 1'b1;
                                    emit      = 1'b1;
                                    emit_kind = EV_RETIRED;
                                    emit_id   = retire_id_reg;
                                end
                            end
                        end
                        OP_WLOCK:
                        begin
                            if (write_held_reg || reader_count_reg != '0)
                            begin
                                if (wq_full)
                                begin
                                    emit      = 1'b1;
                                    emit_kind = EV_WREFUSE;
                                end
                                else
                                begin
                                    wq_we         = 1'b1;
                                    wq_count_next = wq_count_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                write_held_next = 1'b1;
                                emit            = 1'b1;
                                emit_kind       = EV_WGRANT;
                            end
                        end
                        OP_WUNLOCK:
                        begin
                            if (!write_held_reg)
                            begin
                                emit      = 1'b1;
                                emit_kind = EV_ERROR;
                            end
                            else if (rq_count_reg != '0)
                            begin
                                write_held_next = 1'b0;
                                emitted_next    = '0;
                                state_next      = S_DRAIN;
                            end
                            else if (wq_count_reg != '0)
                            begin
                                wq_pop    = 1'b1;
                                emit      = 1'b1;
                                emit_kind = EV_WGRANT;
                                emit_id   = wq_rdata;
                            end
                            else if (retire_pending_reg)
                            begin
                                do_reset  = 1'b1;
                                emit      = 1'b1;
                                emit_kind = EV_RETIRED;
                                emit_id   = retire_id_reg;
                            end
                            else
                            begin
                                write_held_next = 1'b0;
                            end
                        end
                        OP_RETIRE:
                        begin
                            if (retire_pending_reg)
                            begin
                                emit      = 1'b1;
                                emit_kind = EV_ERROR;
                            end
                            else if (!write_held_reg && reader_count_reg == '0)
                            begin
                                do_reset  = 1'b1;
                                emit      = 1'b1;
                                emit_kind = EV_RETIRED;
                            end
                            else
                            begin
                                retire_pending_next = 1'b1;
                                retire_id_next      = id_reg;
                            end
                        end
                        default:
                        begin
                            emit      = 1'b1;
                            emit_kind = EV_ERROR;
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    rq_pop            = 1'b1;
                    reader_count_next = reader_count_reg + 1'b1;
                    emitted_next      = emitted_reg + 1'b1;
                    emit              = 1'b1;
                    emit_kind         = EV_RGRANT;
                    emit_id           = rq_rdata;
                    emit_last         = !(rq_count_reg > RQ_CW'(1) &&
                                          reader_count_reg < RC_W'(MAX_READERS - 1) &&
                                          emitted_reg < EC_W'(RESULT_CAP - 1));
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rq_pop)
        begin
            rq_head_next  = rq_head_inc;
            rq_count_next = rq_count_reg - 1'b1;
        end
        if (wq_pop)
        begin
            wq_head_next  = wq_head_inc;
            wq_count_next = wq_count_reg - 1'b1;
        end
        if (do_reset)
        begin
            write_held_next     = 1'b0;
            reader_count_next   = '0;
            rq_head_next        = '0;
            rq_count_next       = '0;
            wq_head_next        = '0;
            wq_count_next       = '0;
            retire_pending_next = 1'b0;
            retire_id_next      = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_id_next    = emit_id;
            out_last_next  = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            write_held_reg     <= 1'b0;
            reader_count_reg   <= '0;
            rq_head_reg        <= '0;
            rq_count_reg       <= '0;
            wq_head_reg        <= '0;
            wq_count_reg       <= '0;
            retire_pending_reg <= 1'b0;
            retire_id_reg      <= '0;
            emitted_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            write_held_reg     <= write_held_next;
            reader_count_reg   <= reader_count_next;
            rq_head_reg        <= rq_head_next;
            rq_count_reg       <= rq_count_next;
            wq_head_reg        <= wq_head_next;
            wq_count_reg       <= wq_count_next;
            retire_pending_reg <= retire_pending_next;
            retire_id_reg      <= retire_id_next;
            emitted_reg        <= emitted_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
    end

    // read port follows the next head so the RAM's registered output holds the word for the next pop
    assign rq_raddr = rq_head_next;
    assign wq_raddr = wq_head_next;
    assign rq_waddr = rq_tail;
    assign wq_waddr = wq_tail;
    assign rq_wdata = id_reg;
    assign wq_wdata = id_reg;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign event_kind  = out_kind_reg;
    assign target_id   = TID_W'(out_id_reg);
    assign last_of_run = out_last_reg;

    assign status.busy         = (state_reg != S_IDLE);
    assign status.write_held   = write_held_reg;
    assign status.reader_count = reader_count_reg;
    assign status.rq_count     = rq_count_reg;
    assign status.wq_count     = wq_count_reg;

endmodule
